### sv/svpwm_zero_sequence_duty_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the zero sequence duty block
// Concurrent assertion helpers that compile to nothing when ASSERT_OFF is set.
// -----------------------------------------------------------------------------
`ifndef SVPWM_ZERO_SEQUENCE_DUTY_DEFINES_SVH
`define SVPWM_ZERO_SEQUENCE_DUTY_DEFINES_SVH

`ifndef ASSERT_OFF
`define SVZSD_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("svzsd assertion failed");
`define SVZSD_ASSERT(lbl, prop) \
  `SVZSD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define SVZSD_ASSERT_CLK(lbl, clk, rstn, prop)
`define SVZSD_ASSERT(lbl, prop)
`endif

`endif

### sv/svzsd_pkg.sv
// -----------------------------------------------------------------------------
// Zero sequence duty package
// Word types, fixed-point widths and the duty conversion shared by the RTL.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svzsd_pkg;

  localparam int unsigned VOLT_BITS = 16;
  localparam int unsigned DUTY_BITS = 16;
  localparam int unsigned FRAC_BITS = 16;

  // Normalized command: |n| < 128.0, so 7 integer bits plus sign.
  localparam int unsigned N_BITS    = FRAC_BITS + 8;
  localparam int unsigned SUM_BITS  = N_BITS + 2;
  localparam int unsigned SABS_BITS = N_BITS + 1;
  // Division by three as a multiply by ceil(2^27/3); exact for sums below 2^27.
  localparam int unsigned AVG_SHIFT = 27;
  localparam int unsigned RECIP_BITS = 26;
  localparam logic [RECIP_BITS-1:0] AVG_RECIP = 26'd44739243;
  localparam int unsigned AVG_PROD_BITS = SABS_BITS + RECIP_BITS;

  localparam int unsigned MOD_BITS  = N_BITS + 3;
  localparam int unsigned MAG_BITS  = MOD_BITS - 1;
  localparam int unsigned LIM_BITS  = FRAC_BITS + 2;
  localparam int unsigned PROD_BITS = MAG_BITS + LIM_BITS;
  localparam int unsigned SQ_BITS   = LIM_BITS;
  localparam int unsigned SD_BITS   = PROD_BITS - SQ_BITS;

  localparam logic [15:0] LIMIT_ONE = 16'd32768;
  localparam logic [DUTY_BITS-1:0] DUTY_HALF = DUTY_BITS'(1) << (DUTY_BITS - 1);

  typedef enum logic [1:0] {
    CFG_MOD_LIMIT = 2'd0,
    CFG_MIN_BUS   = 2'd1,
    CFG_FOUR_LEG  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VOLT_BITS-1:0] phase_u_voltage;
    logic signed [VOLT_BITS-1:0] phase_v_voltage;
    logic signed [VOLT_BITS-1:0] phase_w_voltage;
    logic        [VOLT_BITS-1:0] bus_voltage;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty_u;
    logic [DUTY_BITS-1:0] duty_v;
    logic [DUTY_BITS-1:0] duty_w;
    logic [DUTY_BITS-1:0] duty_n;
    logic                 result_valid;
    logic                 was_limited;
  } out_word_t;

  // Duty = (1 + m) / 2 in Q0.D, saturated to the unsigned range.
  function automatic logic [DUTY_BITS-1:0] to_duty(input logic signed [MOD_BITS-1:0] m);
    logic signed [MOD_BITS:0]         t;
    logic [MOD_BITS+DUTY_BITS:0]      w;
    logic [DUTY_BITS-1:0]             d;
    t = (MOD_BITS+1)'(1 << FRAC_BITS) + (MOD_BITS+1)'(m);
    w = {t, {DUTY_BITS{1'b0}}} >> (FRAC_BITS + 1);
    if (t <= 0) begin
      d = '0;
    end else if (w > (MOD_BITS+DUTY_BITS+1)'({DUTY_BITS{1'b1}})) begin
      d = '1;
    end else begin
      d = w[DUTY_BITS-1:0];
    end
    return d;
  endfunction

endpackage

### sv/svpwm_zero_sequence_duty.sv
// -----------------------------------------------------------------------------
// Min-max zero sequence SVPWM duty generator
// Normalizes three phase commands, injects the zero sequence and returns duties.
// -----------------------------------------------------------------------------
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+---------------------------
// input    | in        | in_valid_i/in_stall_o  | in_word_t (3 phases, bus)
// output   | out       | out_valid_o/out_stall_i| out_word_t (4 duties, flags)
// config   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word is taken every cycle while the pipeline is not stalled. A word
// passes 29 register stages (12 stages of the normalizing dividers, 7 merge
// and scaling stages, 9 stages of the limit dividers, one output register);
// the first is loaded at the edge that takes the word. The divider lanes
// supply most of these stages, two quotient bits per stage.
// The whole pipeline advances unless the output register is full and stalled.
// Reset clears the valid bits and sets the configuration registers to defaults.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "svpwm_zero_sequence_duty_defines.svh"

module svpwm_zero_sequence_duty (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svzsd_pkg::in_word_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output svzsd_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  import svzsd_pkg::*;

  localparam int unsigned D1 = N_BITS / 2;
  localparam int unsigned D2 = SQ_BITS / 2;
  localparam int unsigned PIPE = D1 + 7 + D2;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are registered directly, so ready is constant.
  // ---------------------------------------------------------------------------
  logic [15:0] mod_limit_q, min_bus_q;
  logic        four_leg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_limit_q <= LIMIT_ONE;
      min_bus_q   <= 16'd1;
      four_leg_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MOD_LIMIT: mod_limit_q <= cfg_data_i;
        CFG_MIN_BUS:   min_bus_q   <= cfg_data_i;
        CFG_FOUR_LEG:  four_leg_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Limit in Q2.F, with anything above 1.0 clamped to 1.0.
  logic [15:0]           lim_raw;
  logic [15+FRAC_BITS:0] lim_wide;
  logic [LIM_BITS-1:0]   lim;

  always_comb begin
    lim_raw  = (mod_limit_q > LIMIT_ONE) ? LIMIT_ONE : mod_limit_q;
    lim_wide = {lim_raw, {FRAC_BITS{1'b0}}};
    lim      = LIM_BITS'(lim_wide >> 15);
  end

  // ---------------------------------------------------------------------------
  // Flow control: a single advance strobe moves every stage together.
  // ---------------------------------------------------------------------------
  logic            adv, accept;
  logic [PIPE-1:0] vld_q;
  logic            out_vld_q;
  out_word_t       out_word_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: magnitudes, rejection check, and the three normalizing lanes.
  // The command is rejected when |v| >= 64 * Vdc, which is |2v/Vdc| >= 128.
  // ---------------------------------------------------------------------------
  logic signed [VOLT_BITS-1:0] vin [3];
  logic [VOLT_BITS:0]          vmag [3];
  logic [2:0]                  vneg, vbig;
  logic                        in_ok;
  logic [N_BITS-1:0]           quo1 [3];

  assign vin[0] = in_word_i.phase_u_voltage;
  assign vin[1] = in_word_i.phase_v_voltage;
  assign vin[2] = in_word_i.phase_w_voltage;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vneg[i] = vin[i][VOLT_BITS-1];
      vmag[i] = vneg[i] ? (VOLT_BITS+1)'(-(VOLT_BITS+1)'(vin[i]))
                        : (VOLT_BITS+1)'(vin[i]);
      vbig[i] = ((VOLT_BITS+6)'(vmag[i]) >= {in_word_i.bus_voltage, 6'b0});
    end
    in_ok = (in_word_i.bus_voltage != '0) && (in_word_i.bus_voltage >= min_bus_q)
            && (vbig == 3'b000);
  end

  for (genvar l = 0; l < 3; l++) begin : g_norm
    svzsd_div #(
      .DBITS(VOLT_BITS),
      .QBITS(N_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .en_i    (adv),
      .num_hi_i(VOLT_BITS'(vmag[l] >> 7)),
      .num_lo_i(N_BITS'({vmag[l][6:0], {(FRAC_BITS+1){1'b0}}})),
      .den_i   (in_word_i.bus_voltage),
      .quo_o   (quo1[l])
    );
  end

  // Sign and acceptance flags travel beside the dividers.
  logic       sb1_ok_q  [D1];
  logic [2:0] sb1_neg_q [D1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb1_ok_q[0]  <= in_ok;
      sb1_neg_q[0] <= vneg;
      for (int k = 1; k < D1; k++) begin
        sb1_ok_q[k]  <= sb1_ok_q[k-1];
        sb1_neg_q[k] <= sb1_neg_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Merge stages: average removal, min-max injection, limit search.
  // ---------------------------------------------------------------------------
  logic signed [N_BITS-1:0]   n_w [3];
  logic signed [SUM_BITS-1:0] sum_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_w[i] = sb1_neg_q[D1-1][i] ? N_BITS'(-$signed(quo1[i])) : $signed(quo1[i]);
    end
    sum_w = SUM_BITS'(n_w[0]) + SUM_BITS'(n_w[1]) + SUM_BITS'(n_w[2]);
  end

  // Stage A: normalized values and the sum magnitude.
  logic signed [N_BITS-1:0] a_n_q [3];
  logic [SABS_BITS-1:0]     a_sabs_q;
  logic                     a_sneg_q, a_ok_q;
  // Stage B: sum divided by three, before the sign comes back.
  logic signed [N_BITS-1:0] b_n_q [3];
  logic [AVG_PROD_BITS-1:0] b_prod_q;
  logic                     b_sneg_q, b_ok_q;
  // Stage C: centered values.
  logic signed [N_BITS:0]   c_c_q [3];
  logic signed [N_BITS-1:0] c_avg_q;
  logic                     c_ok_q;
  // Stage D: zero sequence.
  logic signed [N_BITS:0]   d_c_q [3];
  logic signed [N_BITS-1:0] d_avg_q;
  logic signed [MOD_BITS-1:0] d_z_q;
  logic                     d_ok_q;
  // Stage E: leg modulations and magnitudes.
  logic signed [MOD_BITS-1:0] e_m_q [4];
  logic [MAG_BITS-1:0]        e_mag_q [4];
  logic                       e_ok_q;
  // Stage F: largest magnitude.
  logic signed [MOD_BITS-1:0] f_m_q [4];
  logic [MAG_BITS-1:0]        f_mag_q [4];
  logic [MAG_BITS-1:0]        f_big_q;
  logic                       f_ok_q;
  // Stage G: scaling products.
  logic signed [MOD_BITS-1:0] g_m_q [4];
  logic [PROD_BITS-1:0]       g_p_q [4];
  logic [MAG_BITS-1:0]        g_big_q;
  logic                       g_hit_q, g_ok_q;

  logic signed [N_BITS-1:0]   avg_w;
  logic [N_BITS-1:0]          avg_mag;
  logic signed [N_BITS:0]     mx_w, mn_w;
  logic signed [N_BITS+1:0]   zs_w, zadj_w, zhalf_w;
  logic signed [MOD_BITS-1:0] m_w [4];
  logic [MAG_BITS-1:0]        big01, big23, big_w;

  always_comb begin
    avg_mag = b_prod_q[AVG_SHIFT +: N_BITS];
    avg_w   = b_sneg_q ? N_BITS'(-$signed(avg_mag)) : $signed(avg_mag);

    // The zero sequence is formed from the centered values of stage C so that
    // it lands in stage D beside the same word.
    mx_w = c_c_q[0];
    mn_w = c_c_q[0];
    for (int i = 1; i < 3; i++) begin
      if (c_c_q[i] > mx_w) mx_w = c_c_q[i];
      if (c_c_q[i] < mn_w) mn_w = c_c_q[i];
    end
    // Halving truncates toward zero, as a signed division does.
    zs_w    = (N_BITS+2)'(mx_w) + (N_BITS+2)'(mn_w);
    zadj_w  = zs_w + ((zs_w < 0) ? (N_BITS+2)'(1) : (N_BITS+2)'(0));
    zhalf_w = zadj_w >>> 1;

    for (int i = 0; i < 3; i++) begin
      m_w[i] = MOD_BITS'(d_c_q[i]) + d_z_q;
    end
    m_w[3] = four_leg_q ? (d_z_q - MOD_BITS'(d_avg_q)) : '0;

    big01 = (e_mag_q[0] > e_mag_q[1]) ? e_mag_q[0] : e_mag_q[1];
    big23 = (e_mag_q[2] > e_mag_q[3]) ? e_mag_q[2] : e_mag_q[3];
    big_w = (big01 > big23) ? big01 : big23;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_n_q[i] <= n_w[i];
        b_n_q[i] <= a_n_q[i];
        c_c_q[i] <= (N_BITS+1)'(b_n_q[i]) - (N_BITS+1)'(avg_w);
        d_c_q[i] <= c_c_q[i];
      end
      a_sabs_q <= (sum_w < 0) ? SABS_BITS'(-sum_w) : SABS_BITS'(sum_w);
      a_sneg_q <= (sum_w < 0);
      a_ok_q   <= sb1_ok_q[D1-1];

      b_prod_q <= AVG_PROD_BITS'(a_sabs_q) * AVG_PROD_BITS'(AVG_RECIP);
      b_sneg_q <= a_sneg_q;
      b_ok_q   <= a_ok_q;

      c_avg_q  <= avg_w;
      c_ok_q   <= b_ok_q;

      d_avg_q  <= c_avg_q;
      d_z_q    <= MOD_BITS'(-zhalf_w);
      d_ok_q   <= c_ok_q;

      for (int i = 0; i < 4; i++) begin
        e_m_q[i]   <= m_w[i];
        e_mag_q[i] <= (m_w[i] < 0) ? MAG_BITS'(-m_w[i]) : MAG_BITS'(m_w[i]);
        f_m_q[i]   <= e_m_q[i];
        f_mag_q[i] <= e_mag_q[i];
        g_m_q[i]   <= f_m_q[i];
        g_p_q[i]   <= PROD_BITS'(f_mag_q[i]) * PROD_BITS'(lim);
      end
      e_ok_q  <= d_ok_q;
      f_big_q <= big_w;
      f_ok_q  <= e_ok_q;
      g_big_q <= f_big_q;
      g_hit_q <= (f_big_q > MAG_BITS'(lim));
      g_ok_q  <= f_ok_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Scaling lanes: |m| * L / max|m|, one divider per leg.
  // ---------------------------------------------------------------------------
  logic [SQ_BITS-1:0] quo2 [4];

  for (genvar l = 0; l < 4; l++) begin : g_scale
    svzsd_div #(
      .DBITS(SD_BITS),
      .QBITS(SQ_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .en_i    (adv),
      .num_hi_i(g_p_q[l][PROD_BITS-1:SQ_BITS]),
      .num_lo_i(g_p_q[l][SQ_BITS-1:0]),
      .den_i   (g_big_q),
      .quo_o   (quo2[l])
    );
  end

  logic signed [MOD_BITS-1:0] sb2_m_q [D2][4];
  logic                       sb2_hit_q [D2];
  logic                       sb2_ok_q  [D2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb2_m_q[0]   <= g_m_q;
      sb2_hit_q[0] <= g_hit_q;
      sb2_ok_q[0]  <= g_ok_q;
      for (int k = 1; k < D2; k++) begin
        sb2_m_q[k]   <= sb2_m_q[k-1];
        sb2_hit_q[k] <= sb2_hit_q[k-1];
        sb2_ok_q[k]  <= sb2_ok_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: pick scaled or plain modulation, convert to duty, register.
  // Rejected words carry fifty percent on every leg.
  // ---------------------------------------------------------------------------
  logic signed [MOD_BITS-1:0] mf_w [4];
  logic signed [MOD_BITS-1:0] qs_w [4];
  logic [DUTY_BITS-1:0]       duty_w [4];
  out_word_t                  out_word_d;
  logic                       fin_ok, fin_hit;

  always_comb begin
    fin_ok  = sb2_ok_q[D2-1];
    fin_hit = sb2_hit_q[D2-1];
    for (int i = 0; i < 4; i++) begin
      qs_w[i]   = $signed(MOD_BITS'(quo2[i]));
      if (fin_hit) begin
        mf_w[i] = (sb2_m_q[D2-1][i] < 0) ? -qs_w[i] : qs_w[i];
      end else begin
        mf_w[i] = sb2_m_q[D2-1][i];
      end
      duty_w[i] = fin_ok ? to_duty(mf_w[i]) : DUTY_HALF;
    end
    out_word_d.duty_u       = duty_w[0];
    out_word_d.duty_v       = duty_w[1];
    out_word_d.duty_w       = duty_w[2];
    out_word_d.duty_n       = duty_w[3];
    out_word_d.result_valid = fin_ok;
    out_word_d.was_limited  = fin_ok && fin_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[PIPE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SVZSD_ASSERT(a_rejected_neutral,
    out_valid_o && !out_word_o.result_valid |->
      !out_word_o.was_limited && out_word_o.duty_u == DUTY_HALF &&
      out_word_o.duty_v == DUTY_HALF && out_word_o.duty_w == DUTY_HALF &&
      out_word_o.duty_n == DUTY_HALF)
  `SVZSD_ASSERT(a_limited_needs_valid,
    out_valid_o && out_word_o.was_limited |-> out_word_o.result_valid)
  `SVZSD_ASSERT(a_stall_only_when_full,
    in_stall_o == (out_valid_o && out_stall_i))

endmodule

### sv/svzsd_div.sv
// -----------------------------------------------------------------------------
// Pipelined restoring divider lane
// Two quotient bits per stage; the upper dividend part must be below the divisor.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svzsd_div #(
  parameter int unsigned DBITS = 16,
  parameter int unsigned QBITS = 24
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DBITS-1:0] num_hi_i,
  input  logic [QBITS-1:0] num_lo_i,
  input  logic [DBITS-1:0] den_i,
  output logic [QBITS-1:0] quo_o
);

  localparam int unsigned STAGES = QBITS / 2;

  logic [DBITS-1:0] rem_q [STAGES];
  logic [QBITS-1:0] lo_q  [STAGES];
  logic [DBITS-1:0] den_q [STAGES];
  logic [QBITS-1:0] quo_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DBITS-1:0] rem_in, rem_mid, rem_d;
    logic [QBITS-1:0] lo_in, quo_in;
    logic [DBITS-1:0] den_in;
    logic [DBITS:0]   t0, t1;
    logic             b0, b1;

    if (s == 0) begin : g_first
      assign rem_in = num_hi_i;
      assign lo_in  = num_lo_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      t0      = {rem_in, lo_in[QBITS-1]};
      b0      = (t0 >= {1'b0, den_in});
      rem_mid = b0 ? DBITS'(t0 - {1'b0, den_in}) : t0[DBITS-1:0];
      t1      = {rem_mid, lo_in[QBITS-2]};
      b1      = (t1 >= {1'b0, den_in});
      rem_d   = b1 ? DBITS'(t1 - {1'b0, den_in}) : t1[DBITS-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        lo_q[s]  <= {lo_in[QBITS-3:0], 2'b00};
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QBITS-3:0], b0, b1};
      end
    end
  end

  assign quo_o = quo_q[STAGES-1];

endmodule
